// File: hw/rtl/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg: shared types and codes of the lockset race detector
// Event kinds, phases, status codes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package lrd_pkg;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_WRITE   = 3'd2;
  localparam logic [2:0] KIND_ACQUIRE = 3'd3;
  localparam logic [2:0] KIND_RELEASE = 3'd4;

  localparam logic [1:0] PH_EXCL     = 2'd0;
  localparam logic [1:0] PH_SHARED   = 2'd1;
  localparam logic [1:0] PH_SHMOD    = 2'd2;
  localparam logic [1:0] PH_REPORTED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSTART = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_run;
    logic update;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/lockset_race_detector.sv
// Start, acquire, release and unknown events, and accesses by threads not
// started, go straight to the output word; other reads and writes first run
// the address scan, reading one variable table entry per cycle, then an update.
// Throughput: one event at a time; the next word is taken once the result
// has entered the output register.
// Reset: synchronous; clears thread table and entry valid bits at once.
// ----------------------------------------------------------------------------
// lockset_race_detector: lockset based data race detector
// Tracks held locks per thread and a phase and candidate lockset per
// variable, flagging accesses whose protecting lockset becomes empty.
// ----------------------------------------------------------------------------
`default_nettype none
module lockset_race_detector #(
  parameter int NUM_THREADS   = 16,
  parameter int NUM_LOCKS     = 64,
  parameter int NUM_VARIABLES = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // kind[2:0], thread_id[6:3], address[54:7],
                                     // lock_index[60:55], zero[63:61]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_data,      // report_once
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata   // race[0], race_on_write[1], status[3:2],
                                     // variable_phase[5:4], zero[7:6]
);

  lrd_pkg::cmd_t  cmd;
  lrd_pkg::stat_t stat;

  lrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrd_datapath #(
    .NUM_THREADS   (NUM_THREADS),
    .NUM_LOCKS     (NUM_LOCKS),
    .NUM_VARIABLES (NUM_VARIABLES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (s_axis_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// File: hw/rtl/lrd_ctrl.sv
// ----------------------------------------------------------------------------
// lrd_ctrl: sequencer of the lockset race detector
// Steps one event word through decode, table scan and entry update (reads and writes only) and output.
// ----------------------------------------------------------------------------
`default_nettype none
module lrd_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_tvalid,
  output logic           in_tready,
  input  lrd_pkg::stat_t stat,
  output lrd_pkg::cmd_t  cmd
);

  lrd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lrd_pkg::S_IDLE: begin
        if (in_tvalid) state_next = lrd_pkg::S_EXEC;
      end
      lrd_pkg::S_EXEC: begin
        state_next = stat.need_scan ? lrd_pkg::S_SCAN : lrd_pkg::S_DONE;
      end
      lrd_pkg::S_SCAN: begin
        if (stat.scan_done) state_next = lrd_pkg::S_UPDATE;
      end
      lrd_pkg::S_UPDATE: begin
        state_next = lrd_pkg::S_DONE;
      end
      lrd_pkg::S_DONE: begin
        if (stat.out_free) state_next = lrd_pkg::S_IDLE;
      end
      default: state_next = lrd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state)
      lrd_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      lrd_pkg::S_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.scan_start = stat.need_scan;
      end
      lrd_pkg::S_SCAN:   cmd.scan_run = 1'b1;
      lrd_pkg::S_UPDATE: cmd.update   = 1'b1;
      lrd_pkg::S_DONE:   cmd.push     = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/lrd_datapath.sv
// ----------------------------------------------------------------------------
// lrd_datapath: thread table, variable table and phase update logic
// Holds the request, the per-thread lock vectors, the variable memory with
// its valid bits, the address scan and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lrd_datapath #(
  parameter int NUM_THREADS   = 16,
  parameter int NUM_LOCKS     = 64,
  parameter int NUM_VARIABLES = 256
) (
  input  wire            clk,
  input  wire            rst,
  input  lrd_pkg::cmd_t  cmd,
  output lrd_pkg::stat_t stat,
  input  wire  [63:0]    in_tdata,
  input  wire            cfg_valid,
  output logic           cfg_ready,
  input  wire  [0:0]     cfg_data,
  output logic           out_tvalid,
  input  wire            out_tready,
  output logic [7:0]     out_tdata
);

  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int VW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
  localparam int NL = NUM_LOCKS;

  logic           report_once;
  logic [2:0]     req_kind;
  logic [3:0]     req_tid;
  logic [47:0]    req_addr;
  logic [5:0]     req_lidx;

  logic           started [NUM_THREADS];
  logic [NL-1:0]  held_locks [NUM_THREADS];
  logic           valid [NUM_VARIABLES];

  logic [47:0]    mem_addr  [NUM_VARIABLES];
  logic [1:0]     mem_phase [NUM_VARIABLES];
  logic [3:0]     mem_owner [NUM_VARIABLES];
  logic [NL-1:0]  mem_cand  [NUM_VARIABLES];

  logic           rd_valid;
  logic [47:0]    rd_addr;
  logic [1:0]     rd_phase;
  logic [3:0]     rd_owner;
  logic [NL-1:0]  rd_cand;

  logic [VW:0]    scan_cnt;
  logic [VW-1:0]  rd_idx;
  logic           cmp_vld;
  logic [VW-1:0]  cmp_idx;
  logic           free_found;
  logic [VW-1:0]  free_idx;
  logic           hit;
  logic [VW-1:0]  hit_idx;
  logic [1:0]     hit_phase;
  logic [3:0]     hit_owner;
  logic [NL-1:0]  hit_cand;

  logic           res_race;
  logic           res_row;
  logic [1:0]     res_status;
  logic [1:0]     res_phase;

  logic           tid_ok;
  logic [TW-1:0]  tidx;
  logic           known;
  logic [NL-1:0]  held;
  logic [NL-1:0]  lbit;
  logic           is_write;
  logic           issue;
  logic           hit_now;

  logic [1:0]     upd_phase;
  logic [NL-1:0]  upd_cand;
  logic           upd_race;

  logic           mem_we;
  logic [VW-1:0]  mem_wa;
  logic [1:0]     mem_wphase;
  logic [3:0]     mem_wowner;
  logic [NL-1:0]  mem_wcand;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_once <= 1'b1;
    end else if (cfg_valid) begin
      report_once <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= in_tdata[2:0];
      req_tid  <= in_tdata[6:3];
      req_addr <= in_tdata[54:7];
      req_lidx <= in_tdata[60:55];
    end
  end

  assign tid_ok   = 32'(req_tid) < NUM_THREADS;
  assign tidx     = TW'(req_tid);
  assign known    = tid_ok && started[tidx];
  assign held     = held_locks[tidx];
  assign lbit     = (32'(req_lidx) < NL) ? (NL'(1) << req_lidx) : '0;
  assign is_write = (req_kind == lrd_pkg::KIND_WRITE);

  // Thread table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_THREADS; t++) begin
        started[t]    <= 1'b0;
        held_locks[t] <= '0;
      end
    end else if (cmd.exec) begin
      case (req_kind)
        lrd_pkg::KIND_START:   if (tid_ok) started[tidx] <= 1'b1;
        lrd_pkg::KIND_ACQUIRE: if (known) held_locks[tidx] <= held | lbit;
        lrd_pkg::KIND_RELEASE: if (known) held_locks[tidx] <= held & ~lbit;
        default: ;
      endcase
    end
  end

  assign stat.need_scan = known &&
      (req_kind == lrd_pkg::KIND_READ || req_kind == lrd_pkg::KIND_WRITE);

  // Address scan: one read issued per cycle, compared in the next cycle.
  assign issue   = cmd.scan_run && (scan_cnt < (VW+1)'(NUM_VARIABLES));
  assign rd_idx  = scan_cnt[VW-1:0];
  assign hit_now = cmp_vld && rd_valid && (rd_addr == req_addr);
  assign stat.scan_done = cmd.scan_run &&
      (hit_now || (cmp_vld && cmp_idx == VW'(NUM_VARIABLES - 1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt   <= '0;
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
      hit        <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_cnt   <= '0;
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
      hit        <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_vld <= issue;
      cmp_idx <= rd_idx;
      if (issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      // Entries are compared in index order, so the first empty one seen is
      // the lowest free entry.
      if (cmp_vld && !rd_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (hit_now && !hit) begin
        hit       <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_phase <= rd_phase;
        hit_owner <= rd_owner;
        hit_cand  <= rd_cand;
      end
    end
  end

  // Phase transition of a matched entry.
  always_comb begin
    upd_phase = hit_phase;
    upd_cand  = hit_cand;
    upd_race  = 1'b0;
    case (hit_phase)
      lrd_pkg::PH_EXCL: begin
        if (hit_owner != req_tid) begin
          upd_cand = held;
          if (is_write) begin
            upd_phase = lrd_pkg::PH_SHMOD;
            upd_race  = (held == '0);
          end else begin
            upd_phase = lrd_pkg::PH_SHARED;
          end
        end
      end
      lrd_pkg::PH_SHARED: begin
        upd_cand = hit_cand & held;
        if (is_write) begin
          upd_phase = lrd_pkg::PH_SHMOD;
          upd_race  = ((hit_cand & held) == '0);
        end
      end
      lrd_pkg::PH_SHMOD: begin
        upd_cand = hit_cand & held;
        upd_race = ((hit_cand & held) == '0);
      end
      default: ;
    endcase
    if (upd_race && report_once) upd_phase = lrd_pkg::PH_REPORTED;
  end

  assign mem_we     = cmd.update && (hit || free_found);
  assign mem_wa     = hit ? hit_idx : free_idx;
  assign mem_wphase = hit ? upd_phase : lrd_pkg::PH_EXCL;
  assign mem_wowner = hit ? hit_owner : req_tid;
  assign mem_wcand  = hit ? upd_cand : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_addr[mem_wa]  <= req_addr;
      mem_phase[mem_wa] <= mem_wphase;
      mem_owner[mem_wa] <= mem_wowner;
      mem_cand[mem_wa]  <= mem_wcand;
    end
    rd_valid <= valid[rd_idx];
    rd_addr  <= mem_addr[rd_idx];
    rd_phase <= mem_phase[rd_idx];
    rd_owner <= mem_owner[rd_idx];
    rd_cand  <= mem_cand[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < NUM_VARIABLES; v++) valid[v] <= 1'b0;
    end else if (cmd.update && !hit && free_found) begin
      valid[free_idx] <= 1'b1;
    end
  end

  // Result staging.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_race   <= 1'b0;
      res_row    <= 1'b0;
      res_phase  <= lrd_pkg::PH_EXCL;
      res_status <= lrd_pkg::ST_OK;
      case (req_kind)
        lrd_pkg::KIND_START: if (!tid_ok) res_status <= lrd_pkg::ST_NOSTART;
        lrd_pkg::KIND_READ, lrd_pkg::KIND_WRITE, lrd_pkg::KIND_ACQUIRE,
        lrd_pkg::KIND_RELEASE: if (!known) res_status <= lrd_pkg::ST_NOSTART;
        default: ;
      endcase
    end else if (cmd.update) begin
      if (hit) begin
        res_race   <= upd_race;
        res_row    <= upd_race && is_write;
        res_phase  <= upd_phase;
        res_status <= lrd_pkg::ST_OK;
      end else begin
        res_race   <= 1'b0;
        res_row    <= 1'b0;
        res_phase  <= lrd_pkg::PH_EXCL;
        res_status <= free_found ? lrd_pkg::ST_OK : lrd_pkg::ST_FULL;
      end
    end
  end

  assign stat.out_free = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.push) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_tdata <= {2'b00, res_phase, res_status, res_row, res_race};
    end
  end

endmodule
`default_nettype wire
